FILE: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants for the serial frame checker: header field
// positions, reason codes, the configuration set and the verdict record.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int CNT_W    = 16;
  localparam int HEAD_POS = 0;
  localparam int ADDR_POS = 1;
  localparam int LEN_POS  = 3;

  // one past the last header byte
  localparam int HDR_END_A = (HEAD_POS + 1 > ADDR_POS + 2) ? HEAD_POS + 1 : ADDR_POS + 2;
  localparam int HDR_END   = (HDR_END_A > LEN_POS + 2) ? HDR_END_A : LEN_POS + 2;
  localparam int MIN_LEN   = HDR_END + 3;

  localparam logic [7:0]  HEAD_RST = 8'd104;
  localparam logic [7:0]  TAIL_RST = 8'd22;
  localparam logic [15:0] ADDR_RST = 16'h9999;

  // configuration register indexes
  localparam logic [1:0] CFG_HEAD = 2'd0;
  localparam logic [1:0] CFG_TAIL = 2'd1;
  localparam logic [1:0] CFG_ADDR = 2'd2;

  typedef enum logic [2:0] {
    RSN_OK   = 3'd0,
    RSN_HEAD = 3'd1,
    RSN_ADDR = 3'd2,
    RSN_LEN  = 3'd3,
    RSN_TAIL = 3'd4,
    RSN_SUM  = 3'd5
  } reason_t;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  tail_byte;
    logic [15:0] station_address;
  } cfg_t;

  typedef struct packed {
    logic        frame_ok;
    reason_t     fail_reason;
    logic [15:0] frame_length;
  } verdict_t;

endpackage

FILE: rtl/sfc_core.sv
// ----------------------------------------------------------------------------
// sfc_core
// Per-frame state and the single-byte evaluation: header checks, length
// capture, running sum, checksum and tail compare, verdict selection.
// ----------------------------------------------------------------------------
module sfc_core
  import sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output logic       emit,
  output verdict_t   verdict
);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]      decl_len_r, decl_len_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       csum_lo_r, csum_lo_nxt;
  reason_t          first_err_r, first_err_nxt;
  logic             verdict_given_r, verdict_given_nxt;

  logic [CNT_W:0] p;
  logic [CNT_W:0] len;
  reason_t        rsn;

  function automatic reason_t note_err(reason_t cur, reason_t code);
    if (cur == RSN_OK || code < cur) begin
      return code;
    end
    return cur;
  endfunction

  always_comb begin
    p                 = {1'b0, byte_count_r};
    decl_len_nxt      = decl_len_r;
    sum_nxt           = sum_r;
    csum_lo_nxt       = csum_lo_r;
    first_err_nxt     = first_err_r;
    verdict_given_nxt = verdict_given_r;
    byte_count_nxt    = byte_count_r;
    emit              = 1'b0;
    rsn               = RSN_OK;

    if (p == (CNT_W+1)'(HEAD_POS) && data_byte != cfg.head_byte) begin
      first_err_nxt = note_err(first_err_nxt, RSN_HEAD);
    end
    if (p == (CNT_W+1)'(ADDR_POS) && data_byte != cfg.station_address[7:0]) begin
      first_err_nxt = note_err(first_err_nxt, RSN_ADDR);
    end
    if (p == (CNT_W+1)'(ADDR_POS + 1) && data_byte != cfg.station_address[15:8]) begin
      first_err_nxt = note_err(first_err_nxt, RSN_ADDR);
    end
    if (p == (CNT_W+1)'(LEN_POS)) begin
      decl_len_nxt[7:0] = data_byte;
    end
    if (p == (CNT_W+1)'(LEN_POS + 1)) begin
      decl_len_nxt[15:8] = data_byte;
    end
    len = {1'b0, decl_len_nxt};

    if (p < (CNT_W+1)'(HDR_END) || p + 17'd3 < len) begin
      sum_nxt = sum_r + {8'd0, data_byte};
    end

    if (p >= (CNT_W+1)'(HDR_END)) begin
      if (p + 17'd3 == len) begin
        csum_lo_nxt = data_byte;
      end
      if (p + 17'd2 == len && {data_byte, csum_lo_r} != sum_nxt) begin
        first_err_nxt = note_err(first_err_nxt, RSN_SUM);
      end
    end

    if (byte_count_r != '1) begin
      byte_count_nxt = byte_count_r + 1'b1;
    end

    if (p + 17'd1 == (CNT_W+1)'(HDR_END)) begin
      if (first_err_nxt == RSN_HEAD || first_err_nxt == RSN_ADDR) begin
        emit = 1'b1;
        rsn  = first_err_nxt;
      end else if (len < (CNT_W+1)'(MIN_LEN)) begin
        emit = 1'b1;
        rsn  = RSN_LEN;
      end
    end else if (p >= (CNT_W+1)'(HDR_END) && p + 17'd1 == len) begin
      emit = 1'b1;
      if (data_byte != cfg.tail_byte) begin
        rsn = RSN_TAIL;
      end else if (first_err_nxt == RSN_SUM) begin
        rsn = RSN_SUM;
      end else begin
        rsn = RSN_OK;
      end
    end

    // truncated frame
    if (!emit && last_byte) begin
      emit = 1'b1;
      rsn  = (first_err_nxt == RSN_HEAD || first_err_nxt == RSN_ADDR) ?
             first_err_nxt : RSN_LEN;
    end

    if (emit) begin
      verdict_given_nxt = 1'b1;
    end

    // after a verdict, bytes are dropped until the end of the buffer
    if (verdict_given_r) begin
      emit           = 1'b0;
      decl_len_nxt   = decl_len_r;
      sum_nxt        = sum_r;
      csum_lo_nxt    = csum_lo_r;
      first_err_nxt  = first_err_r;
      byte_count_nxt = byte_count_r;
    end

    if (last_byte) begin
      byte_count_nxt    = '0;
      decl_len_nxt      = '0;
      sum_nxt           = '0;
      csum_lo_nxt       = '0;
      first_err_nxt     = RSN_OK;
      verdict_given_nxt = 1'b0;
    end

    verdict.frame_ok     = (rsn == RSN_OK);
    verdict.fail_reason  = rsn;
    verdict.frame_length = len[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      decl_len_r      <= '0;
      sum_r           <= '0;
      csum_lo_r       <= '0;
      first_err_r     <= RSN_OK;
      verdict_given_r <= 1'b0;
    end else if (step) begin
      byte_count_r    <= byte_count_nxt;
      decl_len_r      <= decl_len_nxt;
      sum_r           <= sum_nxt;
      csum_lo_r       <= csum_lo_nxt;
      first_err_r     <= first_err_nxt;
      verdict_given_r <= verdict_given_nxt;
    end
  end

endmodule

FILE: rtl/serial_frame_checker_top.sv
// latency: a byte request is registered in the input stage on accept and evaluated
// there; its verdict, if any, goes through the verdict register to the out_ port
// throughput: one byte per cycle; a byte that makes a verdict waits while the
// verdict register is full and not being drained
// reset: synchronous, active low; clears frame state, both stage valids and
// restores head 104, tail 22, station address 0x9999
// ----------------------------------------------------------------------------
// serial_frame_checker_top
// Byte-wise frame checker: input register, evaluation core, verdict register
// and the configuration registers.
// ----------------------------------------------------------------------------
module serial_frame_checker_top
  import sfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // verdict channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_ok,
  output logic [2:0]  out_fail_reason,
  output logic [15:0] out_frame_length,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  verdict_t   out_r;

  logic       emit;
  verdict_t   verdict;
  logic       step;
  logic       in_take;

  // the byte in the stage moves on when it makes no verdict or the verdict
  // register is free (or emptying this cycle)
  assign step     = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;
  assign in_take  = in_valid && in_ready;

  sfc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg_r),
    .emit      (emit),
    .verdict   (verdict)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_byte       <= HEAD_RST;
      cfg_r.tail_byte       <= TAIL_RST;
      cfg_r.station_address <= ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD: cfg_r.head_byte       <= cfg_wdata[7:0];
        CFG_TAIL: cfg_r.tail_byte       <= cfg_wdata[7:0];
        CFG_ADDR: cfg_r.station_address <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_r <= verdict;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_ok     = out_r.frame_ok;
  assign out_fail_reason  = out_r.fail_reason;
  assign out_frame_length = out_r.frame_length;

endmodule

FILE: tb/serial_frame_checker_top_tb.sv
// ----------------------------------------------------------------------------
// serial_frame_checker_top_tb
// Self-checking bench for the byte-wise frame checker. A short table of
// hand-picked frames comes first. Then random frames follow, mostly well
// formed with random faults mixed in, under several station settings. Every
// verdict is compared field by field with its typed table row or a cycle-free model of the checker.
// ----------------------------------------------------------------------------
module serial_frame_checker_top_tb;
  import sfc_pkg::*;

  localparam int ITEMS_PER_SETTING = 340;
  localparam int STALL_LIMIT       = 2000;
  localparam int DRAIN_CYCLES      = 6;

  // one row of the directed table; typed rows carry their verdict
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    verdict_t   res;
  } dir_row_t;

  localparam verdict_t NO_VERDICT = '0;

  // reset settings: head 8'h68, address 16'h9999, tail 8'h16
  localparam dir_row_t DIRECTED [26] = '{
    // wrong head byte, head error beats everything
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h99, 1'b0, 1'b0, NO_VERDICT},
    '{8'h99, 1'b0, 1'b0, NO_VERDICT},
    '{8'h08, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b1, 1'b1, '{1'b0, RSN_HEAD, 16'h0008}},
    // wrong address high byte, largest length field
    '{8'h68, 1'b0, 1'b0, NO_VERDICT},
    '{8'h99, 1'b0, 1'b0, NO_VERDICT},
    '{8'h98, 1'b0, 1'b0, NO_VERDICT},
    '{8'hff, 1'b0, 1'b0, NO_VERDICT},
    '{8'hff, 1'b1, 1'b1, '{1'b0, RSN_ADDR, 16'hffff}},
    // length one below the minimum, then a byte after the verdict
    '{8'h68, 1'b0, 1'b0, NO_VERDICT},
    '{8'h99, 1'b0, 1'b0, NO_VERDICT},
    '{8'h99, 1'b0, 1'b0, NO_VERDICT},
    '{8'h07, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b1, '{1'b0, RSN_LEN, 16'h0007}},
    '{8'h55, 1'b1, 1'b0, NO_VERDICT},
    // buffer ends before the length field
    '{8'h68, 1'b0, 1'b0, NO_VERDICT},
    '{8'h99, 1'b1, 1'b1, '{1'b0, RSN_LEN, 16'h0000}},
    // shortest good frame: no payload
    '{8'h68, 1'b0, 1'b0, NO_VERDICT},
    '{8'h99, 1'b0, 1'b0, NO_VERDICT},
    '{8'h99, 1'b0, 1'b0, NO_VERDICT},
    '{8'h08, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'ha2, 1'b0, 1'b0, NO_VERDICT},
    '{8'h01, 1'b0, 1'b0, NO_VERDICT},
    '{8'h16, 1'b1, 1'b0, NO_VERDICT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_frame_ok;
  logic [2:0]  out_fail_reason;
  logic [15:0] out_frame_length;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_HEAD;
  logic [15:0] cfg_wdata = 16'h0000;

  serial_frame_checker_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_ok     (out_frame_ok),
    .out_fail_reason  (out_fail_reason),
    .out_frame_length (out_frame_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // station settings as the model sees them
  logic [7:0]  cur_head = HEAD_RST;
  logic [7:0]  cur_tail = TAIL_RST;
  logic [15:0] cur_addr = ADDR_RST;

  // frame tracking state of the model
  logic [15:0] fr_pos;
  logic [15:0] fr_len;
  logic [15:0] fr_sum;
  logic [7:0]  fr_csum_lo;
  reason_t     fr_err;
  bit          fr_done;

  verdict_t    verdict_q[$];
  int          n_fail = 0;
  int          n_live = 0;
  int          stall_cycles = 0;
  bit          idle_en = 1'b1;

  function automatic void clear_frame();
    fr_pos     = '0;
    fr_len     = '0;
    fr_sum     = '0;
    fr_csum_lo = '0;
    fr_err     = RSN_OK;
    fr_done    = 1'b0;
  endfunction

  // keep the highest-priority error, lowest code wins
  function automatic void note_err(input reason_t code);
    if (fr_err == RSN_OK || code < fr_err) fr_err = code;
  endfunction

  // advance the frame state by one byte; returns 1 when a verdict falls out
  function automatic bit judge_byte(input logic [7:0] b, input logic last,
                                    output verdict_t v);
    int unsigned p;
    bit          emit;
    reason_t     why;
    p    = fr_pos;
    emit = 1'b0;
    why  = RSN_OK;
    v    = '0;
    if (fr_done) begin
      if (last) clear_frame();
      return 1'b0;
    end
    if (p == HEAD_POS && b != cur_head) note_err(RSN_HEAD);
    if (p == ADDR_POS && b != cur_addr[7:0]) note_err(RSN_ADDR);
    if (p == ADDR_POS + 1 && b != cur_addr[15:8]) note_err(RSN_ADDR);
    if (p == LEN_POS) fr_len[7:0] = b;
    if (p == LEN_POS + 1) fr_len[15:8] = b;
    // the sum covers the header and every byte ahead of the checksum
    if (p < HDR_END || p + 3 < fr_len) fr_sum = fr_sum + b;
    if (p >= HDR_END) begin
      if (p + 3 == fr_len) fr_csum_lo = b;
      if (p + 2 == fr_len && {b, fr_csum_lo} != fr_sum) note_err(RSN_SUM);
    end
    if (fr_pos != 16'hffff) fr_pos = fr_pos + 1'b1;
    if (p + 1 == HDR_END) begin
      // header complete: head or address error first, then a too-short length
      if (fr_err == RSN_HEAD || fr_err == RSN_ADDR) begin
        emit = 1'b1;
        why  = fr_err;
      end else if (fr_len < MIN_LEN) begin
        emit = 1'b1;
        why  = RSN_LEN;
      end
    end else if (p + 1 > HDR_END && p + 1 == fr_len) begin
      emit = 1'b1;
      if (b != cur_tail) why = RSN_TAIL;
      else if (fr_err == RSN_SUM) why = RSN_SUM;
    end
    // buffer ran out before a verdict
    if (!emit && last) begin
      emit = 1'b1;
      why  = (fr_err == RSN_HEAD || fr_err == RSN_ADDR) ? fr_err : RSN_LEN;
    end
    if (emit) begin
      v.frame_ok     = (why == RSN_OK);
      v.fail_reason  = why;
      v.frame_length = fr_len;
    end
    if (last) clear_frame();
    else if (emit) fr_done = 1'b1;
    return emit;
  endfunction

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(255, 1));
  endfunction

  // offer one byte request and book its verdict once it is taken
  task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                           input verdict_t typed_res);
    verdict_t v;
    bit       got;
    // now and then hold off until every pending verdict is out
    if (idle_en && $urandom_range(149) == 0) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (verdict_q.size() != 0);
    end
    if (idle_en)
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    n_live++;
    got = judge_byte(b, last, v);
    if (typed) verdict_q.push_back(typed_res);
    else if (got) verdict_q.push_back(v);
  endtask

  // one random frame, usually well formed, sometimes with faults
  task automatic send_random_frame();
    logic [7:0]  fb[$];
    logic [15:0] flen;
    logic [15:0] fsum;
    int unsigned cut;
    bit          chopped;
    chopped = 1'b0;
    if ($urandom_range(19) == 0) begin
      // line noise
      repeat ($urandom_range(12, 1)) fb.push_back(8'($urandom));
    end else begin
      flen = ($urandom_range(29) == 0) ? 16'($urandom_range(600, 41))
                                       : 16'($urandom_range(40, 8));
      fb.push_back(cur_head);
      fb.push_back(cur_addr[7:0]);
      fb.push_back(cur_addr[15:8]);
      fb.push_back(flen[7:0]);
      fb.push_back(flen[15:8]);
      while (fb.size() < flen - 3) fb.push_back(8'($urandom));
      fsum = '0;
      foreach (fb[i]) fsum = fsum + fb[i];
      fb.push_back(fsum[7:0]);
      fb.push_back(fsum[15:8]);
      fb.push_back(cur_tail);
      if ($urandom_range(9) == 0) fb[HEAD_POS] ^= nonzero_byte();
      if ($urandom_range(9) == 0) fb[ADDR_POS + $urandom_range(1)] ^= nonzero_byte();
      if ($urandom_range(12) == 0) begin
        // length too short to hold header, checksum and tail
        fb[LEN_POS]     = 8'($urandom_range(MIN_LEN - 1));
        fb[LEN_POS + 1] = 8'h00;
      end
      // a payload or checksum byte hit: checksum error
      if ($urandom_range(7) == 0) fb[$urandom_range(flen - 2, HDR_END)] ^= nonzero_byte();
      if ($urandom_range(9) == 0) fb[flen - 1] ^= nonzero_byte();
      if ($urandom_range(9) == 0) begin
        // receive buffer ends early
        chopped = 1'b1;
        cut = $urandom_range(fb.size() - 2);
        while (fb.size() > cut + 1) void'(fb.pop_back());
      end
    end
    // trailing bytes the checker has to skip
    if (!chopped && $urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) fb.push_back(8'($urandom));
    foreach (fb[i]) push_byte(fb[i], i == fb.size() - 1, 1'b0, NO_VERDICT);
  endtask

  // let every request drain so the checker is idle
  task automatic settle(input int cycles);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_settings(input cfg_t s);
    // upper bits of the narrow registers are don't-care, so scramble them
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEAD;
    cfg_wdata <= {8'($urandom), s.head_byte};
    @(posedge clk);
    cfg_index <= CFG_TAIL;
    cfg_wdata <= {8'($urandom), s.tail_byte};
    @(posedge clk);
    cfg_index <= CFG_ADDR;
    cfg_wdata <= s.station_address;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_head = s.head_byte;
    cur_tail = s.tail_byte;
    cur_addr = s.station_address;
  endtask

  // receiver side: random back-pressure except in the quiet stretch
  always @(posedge clk)
    out_ready <= !idle_en || ($urandom_range(99) >= 35);

  // verdict checker
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict: frame_ok %0d fail_reason %0d frame_length %0d",
               out_frame_ok, out_fail_reason, out_frame_length);
        n_fail++;
      end else begin
        want = verdict_q.pop_front();
        if (out_frame_ok !== want.frame_ok) begin
          $error("frame_ok: expected %0d, got %0d", want.frame_ok, out_frame_ok);
          n_fail++;
        end
        if (out_fail_reason !== want.fail_reason) begin
          $error("fail_reason: expected %0d, got %0d", want.fail_reason, out_fail_reason);
          n_fail++;
        end
        if (out_frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 out_frame_length);
          n_fail++;
        end
      end
    end
  end

  // watchdog: too long without any request moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("serial_frame_checker_top test failed");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    cfg_t s;
    clear_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames under the reset settings
    foreach (DIRECTED[r])
      push_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].res);

    // random frames under each station setting; phase 3 runs without idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       s = '{8'h00, 8'h00, 16'h0000};
        1:       s = '{8'hff, 8'hff, 16'hffff};
        4:       s = '{HEAD_RST, TAIL_RST, ADDR_RST};
        default: s = '{8'($urandom), 8'($urandom), 16'($urandom)};
      endcase
      settle(DRAIN_CYCLES);
      write_settings(s);
      idle_en = (ph != 3);
      n_live  = 0;
      while (n_live < ITEMS_PER_SETTING) send_random_frame();
    end

    idle_en = 1'b1;
    settle(DRAIN_CYCLES);
    if (n_fail == 0)
      $display("serial_frame_checker_top test passed");
    else
      $display("serial_frame_checker_top test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/sfc_pkg.sv
rtl/sfc_core.sv
rtl/serial_frame_checker_top.sv
tb/serial_frame_checker_top_tb.sv
